// ===== sv/lcs_permutation_via_lis_assert.svh =====
// assertion macros shared by the lcs permutation block
`ifndef LCS_PERMUTATION_VIA_LIS_ASSERT_SVH
`define LCS_PERMUTATION_VIA_LIS_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define LCSP_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define LCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/lcsp_pkg.sv =====
// shared widths, constants and controller/datapath interface types
package lcsp_pkg;

    localparam int VALUE_W = 11;
    localparam int LEN_W   = 11;
    localparam int EPOCH_W = 4;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'd15;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_STREAM = 1'b1;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic pos_top;
        logic extend;
        logic search;
        logic search_init;
        logic replace;
        logic finish;
        logic clear_step;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic last;
        logic map_hit;
        logic top_lt;
        logic search_more;
        logic repl_lt;
        logic out_free;
        logic wrap;
        logic clear_done;
    } sts_t;

endpackage

// ===== sv/lcsp_ram.sv =====
// generic simple dual-port ram with registered read
module lcsp_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lcsp_ctrl.sv =====
// controller state machine sequencing load, search, result and clear
module lcsp_ctrl import lcsp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POS   = 7'b0000010,
        S_TOP   = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_FINAL = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_CLEAR = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_POS;
                end
            end
            S_POS:
            begin
                if (sts.is_load)
                begin
                    cmd.load_wr = 1'b1;
                    state_next  = S_DONE;
                end
                else if (sts.map_hit)
                begin
                    cmd.pos_top = 1'b1;
                    state_next  = S_TOP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TOP:
            begin
                if (sts.top_lt)
                begin
                    cmd.extend = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.search      = 1'b1;
                    cmd.search_init = 1'b1;
                    state_next      = sts.search_more ? S_PROBE : S_FINAL;
                end
            end
            S_PROBE:
            begin
                cmd.search = 1'b1;
                state_next = sts.search_more ? S_PROBE : S_FINAL;
            end
            S_FINAL:
            begin
                cmd.replace = sts.repl_lt;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.last)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = sts.wrap ? S_CLEAR : S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/lcsp_dp.sv =====
// datapath: position map, tail store, search registers and result register
`include "lcs_permutation_via_lis_assert.svh"

module lcsp_dp import lcsp_pkg::*; #(
    parameter int MAX_N = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               mode,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEN_W-1:0]   lcs_length
);

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int PW = $clog2(MAX_N + 1);
    localparam int MW = EPOCH_W + PW;

    logic               mode_reg;
    logic               mode_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               last_reg;
    logic               last_next;
    logic [PW-1:0]      load_count_reg;
    logic [PW-1:0]      load_count_next;
    logic [PW-1:0]      best_reg;
    logic [PW-1:0]      best_next;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    logic [PW-1:0]      lo_reg;
    logic [PW-1:0]      lo_next;
    logic [PW-1:0]      hi_reg;
    logic [PW-1:0]      hi_next;
    logic [PW-1:0]      mid_reg;
    logic [PW-1:0]      mid_next;
    logic               rd_zero_reg;
    logic               rd_zero_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [LEN_W-1:0]   lcs_length_reg;
    logic [LEN_W-1:0]   lcs_length_next;
    logic [AW-1:0]      clr_cnt_reg;
    logic [AW-1:0]      clr_cnt_next;

    logic               in_range;
    logic               load_ok;
    logic               map_wr_en;
    logic [AW-1:0]      map_wr_addr;
    logic [MW-1:0]      map_wr_data;
    logic [AW-1:0]      map_rd_addr;
    logic [MW-1:0]      map_rd_data;
    logic [EPOCH_W-1:0] map_tag;
    logic [PW-1:0]      map_pos;

    logic               tail_wr_en;
    logic [PW-1:0]      tail_wr_addr;
    logic               tail_rd_en;
    logic [PW-1:0]      tail_rd_addr;
    logic [PW-1:0]      tail_rd_data;
    logic [PW-1:0]      tail_q;
    logic               tail_gt;

    logic [PW-1:0]      nlo;
    logic [PW-1:0]      nhi;
    logic [PW:0]        mid_sum;
    logic [PW-1:0]      mid_new;
    logic               more;
    logic               clear_last;

    assign in_range = (value_reg != '0) && (32'(value_reg) <= 32'(MAX_N));
    assign load_ok  = in_range && (load_count_reg < PW'(MAX_N));

    // position map with epoch tags
    assign map_rd_addr = AW'(value - VALUE_W'(1));
    assign map_wr_en   = cmd.clear_step || (cmd.load_wr && load_ok);
    assign map_wr_addr = cmd.clear_step ? clr_cnt_reg : AW'(value_reg - VALUE_W'(1));
    assign map_wr_data = cmd.clear_step ? '0 : {epoch_reg, load_count_reg + PW'(1)};
    assign map_tag     = map_rd_data[MW-1:PW];
    assign map_pos     = map_rd_data[PW-1:0];

    lcsp_ram #(
        .WIDTH  (MW),
        .DEPTH  (MAX_N),
        .ADDR_W (AW)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (cmd.capture),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    // tail entry zero always reads as zero
    assign tail_q  = rd_zero_reg ? '0 : tail_rd_data;
    assign tail_gt = tail_q > pos_reg;

    // binary search step
    always_comb
    begin
        if (cmd.search_init)
        begin
            nlo = '0;
            nhi = best_reg;
        end
        else if (tail_gt)
        begin
            nlo = lo_reg;
            nhi = mid_reg;
        end
        else
        begin
            nlo = mid_reg + PW'(1);
            nhi = hi_reg;
        end
    end

    assign mid_sum = {1'b0, nlo} + {1'b0, nhi};
    assign mid_new = mid_sum[PW:1];
    assign more    = nlo < nhi;

    assign tail_rd_en   = cmd.pos_top || cmd.search;
    assign tail_rd_addr = cmd.pos_top ? best_reg : (more ? mid_new : nlo);
    assign tail_wr_en   = cmd.extend || cmd.replace;
    assign tail_wr_addr = cmd.extend ? (best_reg + PW'(1)) : lo_reg;

    lcsp_ram #(
        .WIDTH  (PW),
        .DEPTH  (MAX_N + 1),
        .ADDR_W (PW)
    ) u_tail_ram (
        .clk     (clk),
        .wr_en   (tail_wr_en),
        .wr_addr (tail_wr_addr),
        .wr_data (pos_reg),
        .rd_en   (tail_rd_en),
        .rd_addr (tail_rd_addr),
        .rd_data (tail_rd_data)
    );

    assign clear_last = clr_cnt_reg == AW'(MAX_N - 1);

    always_comb
    begin
        mode_next       = mode_reg;
        value_next      = value_reg;
        last_next       = last_reg;
        load_count_next = load_count_reg;
        best_next       = best_reg;
        epoch_next      = epoch_reg;
        pos_next        = pos_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        rd_zero_next    = rd_zero_reg;
        lcs_length_next = lcs_length_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.capture)
        begin
            mode_next  = mode;
            value_next = value;
            last_next  = last;
        end
        if (cmd.load_wr && load_ok)
        begin
            load_count_next = load_count_reg + PW'(1);
        end
        if (cmd.pos_top)
        begin
            pos_next = map_pos;
        end
        if (tail_rd_en)
        begin
            rd_zero_next = tail_rd_addr == '0;
        end
        if (cmd.extend)
        begin
            best_next = best_reg + PW'(1);
        end
        if (cmd.search)
        begin
            lo_next  = nlo;
            hi_next  = nhi;
            mid_next = mid_new;
        end
        if (cmd.finish)
        begin
            lcs_length_next = LEN_W'(best_reg);
            out_valid_next  = 1'b1;
            best_next       = '0;
            load_count_next = '0;
            epoch_next      = (epoch_reg == EPOCH_LAST) ? EPOCH_FIRST : epoch_reg + EPOCH_W'(1);
        end
        if (cmd.clear_step)
        begin
            clr_cnt_next = clear_last ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            best_reg       <= '0;
            epoch_reg      <= EPOCH_FIRST;
            out_valid_reg  <= 1'b0;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            best_reg       <= best_next;
            epoch_reg      <= epoch_next;
            out_valid_reg  <= out_valid_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        value_reg      <= value_next;
        last_reg       <= last_next;
        pos_reg        <= pos_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        rd_zero_reg    <= rd_zero_next;
        lcs_length_reg <= lcs_length_next;
    end

    always_comb
    begin
        sts.is_load     = mode_reg == MODE_LOAD;
        sts.last        = last_reg;
        sts.map_hit     = in_range && (map_tag == epoch_reg);
        sts.top_lt      = tail_q < pos_reg;
        sts.search_more = more;
        sts.repl_lt     = tail_gt;
        sts.out_free    = !out_valid_reg || out_ready;
        sts.wrap        = epoch_reg == EPOCH_LAST;
        sts.clear_done  = clear_last;
    end

    assign out_valid  = out_valid_reg;
    assign lcs_length = lcs_length_reg;

    `LCSP_ASSERT_NOW(a_best_bound, best_reg <= PW'(MAX_N), "lis length beyond table size")
    `LCSP_ASSERT_NOW(a_load_bound, load_count_reg <= PW'(MAX_N), "load count beyond table size")
    `LCSP_ASSERT_NEXT(a_finish_clears, cmd.finish, out_valid_reg && best_reg == '0 && load_count_reg == '0, "run state not cleared after result")
    `LCSP_ASSERT_NEXT(a_search_window, cmd.search, lo_reg <= hi_reg && hi_reg <= best_reg, "search window out of order")

endmodule

// ===== sv/lcs_permutation_via_lis.sv =====
// top level of the lcs-of-permutations block (longest increasing subsequence)
//
//  channel | signals                      | direction
//  in      | in_valid in_ready mode value last | into block
//  out     | out_valid out_ready lcs_length | out of block
//
//  one item at a time; a streamed value that hits the position map and does not
//  extend the longest run goes through a binary search of the tail store,
//  one tail-store read per probe
//  after reset every entry of the position map is cleared before in_ready rises
//  every 15th result repeats that sweep when the epoch tag wraps
//  an item marked last waits in its final state while the previous result is untaken
module lcs_permutation_via_lis import lcsp_pkg::*; #(
    parameter int MAX_N = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEN_W-1:0]   lcs_length
);

    cmd_t cmd;
    sts_t sts;

    lcsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcsp_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .mode       (mode),
        .value      (value),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .lcs_length (lcs_length)
    );

endmodule
